FILE: rtl/quarter_wave_sincos_interp_core_macros.svh
// Assertion helpers for the bind checker in qws_checker.sv.
// Each macro expects clk and rst in scope.
`ifndef QUARTER_WAVE_SINCOS_INTERP_CORE_MACROS_SVH
`define QUARTER_WAVE_SINCOS_INTERP_CORE_MACROS_SVH

// Same-cycle implication.
`define QWS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define QWS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/qws_pkg.sv
package qws_pkg;

  localparam int FRAC_BITS = 8;
  localparam int TURN_W    = 20;
  localparam int IDX_W     = 11;
  localparam int ENTRY_W   = 31;
  localparam int SAMPLE_W  = 32;
  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 64;

  typedef enum logic {
    REQ_WRITE   = 1'b0,
    REQ_COMPUTE = 1'b1
  } req_type_t;

  // s_tdata layout, lowest bits last
  typedef struct packed {
    logic [1:0]         pad;
    logic [ENTRY_W-1:0] entry_value;
    logic [IDX_W-1:0]   entry_index;
    logic [TURN_W-1:0]  turn;
  } in_fields_t;

  // m_tdata layout, lowest bits last
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] cos_value;
    logic signed [SAMPLE_W-1:0] sin_value;
  } out_fields_t;

endpackage

FILE: rtl/quarter_wave_sincos_interp_core.sv
// Quarter-wave sine/cosine core with linear interpolation.
// Input channel s_*: one request per handshake. s_tuser selects the kind:
//   write   - stores entry_value at entry_index of the quarter-wave table
//             (indexes above 2^INDEX_BITS are dropped), no response;
//   compute - turn = {quadrant, index, 8-bit fraction}, one response.
// Output channel m_*: sin_value and cos_value, signed Q1.31.
// The table must be loaded before any compute request reads it; its
// contents are not cleared by reset.
// A compute response is built through the table read registered at the
// accept edge, then setup, multiply and add/negate into the output reg.
// Throughput: one request per clock while s_tready is high. The table
// is split into an even and an odd bank, each read at two addresses per
// cycle, which yields the four neighbor samples that sine and cosine
// need in a single access.
// Back-pressure: each stage holds when the one after it is full and
// held; s_tready drops only when all four stages hold a response. A write
// request never enters the pipeline and is accepted whenever s_tready
// is high. Reset (rst, synchronous, active high) empties the pipeline;
// s_tready is low while rst is asserted.
module quarter_wave_sincos_interp_core #(
  parameter int INDEX_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [19:0] turn, [30:20] entry_index, [61:31] entry_value, [63:62] zero
  input  logic [qws_pkg::S_TDATA_W-1:0] s_tdata,
  // [0] req_type
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [31:0] sin_value, [63:32] cos_value
  output logic [qws_pkg::M_TDATA_W-1:0] m_tdata
);
  import qws_pkg::*;

  localparam int HALF_DEPTH = 1 << (INDEX_BITS - 1);
  localparam int EVEN_DEPTH = HALF_DEPTH + 1;
  localparam int QUAD_LSB   = FRAC_BITS + INDEX_BITS;
  // turn is widened so the quadrant bits always exist (they read as zero
  // when the index is wide enough to push them past bit 19)
  localparam int TURN_X_W   = (QUAD_LSB + 2 > TURN_W) ? QUAD_LSB + 2 : TURN_W;
  localparam int WIDX_W     = (INDEX_BITS + 1 > IDX_W) ? INDEX_BITS + 1 : IDX_W;
  localparam logic [WIDX_W-1:0] TABLE_MAX = WIDX_W'(1 << INDEX_BITS);
  localparam int REP        = SAMPLE_W / FRAC_BITS;

  // per-output interpolation operands
  typedef struct packed {
    logic [SAMPLE_W-1:0] base;   // start sample, already negated if needed
    logic [SAMPLE_W-1:0] delta;  // hi - lo, wraps mod 2^32
    logic                add;    // 1: base + step, 0: base - step
  } lane_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] base;
    logic [SAMPLE_W-1:0] step;
    logic                add;
  } sum_t;

  // ---------------------------------------------------------------------
  // Handshake / stage enables
  // ---------------------------------------------------------------------
  logic v1, v2, v3;
  logic en0, en1, en2, en3;

  assign en3      = !m_tvalid || m_tready;
  assign en2      = !v3 || en3;
  assign en1      = !v2 || en2;
  assign en0      = !v1 || en1;
  assign s_tready = en0 && !rst;

  // ---------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------
  in_fields_t               in_req;
  logic [TURN_X_W-1:0]      turn_x;
  logic [FRAC_BITS-1:0]     frac_in;
  logic [INDEX_BITS-1:0]    idx_a;     // forward pair start i
  logic [INDEX_BITS-1:0]    idx_b;     // backward pair start MAX-1-i
  logic [1:0]               quad_in;
  logic [WIDX_W-1:0]        widx_x;
  logic                     accept, do_write, do_comp;

  assign in_req  = in_fields_t'(s_tdata);
  assign turn_x  = TURN_X_W'(in_req.turn);
  assign frac_in = turn_x[FRAC_BITS-1:0];
  assign idx_a   = turn_x[QUAD_LSB-1:FRAC_BITS];
  assign idx_b   = ~idx_a;
  assign quad_in = turn_x[QUAD_LSB+1:QUAD_LSB];
  assign widx_x  = WIDX_W'(in_req.entry_index);

  assign accept   = s_tvalid && s_tready;
  assign do_write = accept && (s_tuser == REQ_WRITE) && (widx_x <= TABLE_MAX);
  assign do_comp  = accept && (s_tuser == REQ_COMPUTE);

  // Entry k lives in the even bank at k/2 or the odd bank at (k-1)/2.
  // A pair (k, k+1) always touches one entry of each bank.
  logic [INDEX_BITS-1:0]   even_ra_a, even_ra_b, even_wa;
  logic [INDEX_BITS-2:0]   odd_ra_a, odd_ra_b, odd_wa;

  assign even_ra_a = {1'b0, idx_a[INDEX_BITS-1:1]} + INDEX_BITS'(idx_a[0]);
  assign even_ra_b = {1'b0, idx_b[INDEX_BITS-1:1]} + INDEX_BITS'(idx_b[0]);
  assign odd_ra_a  = idx_a[INDEX_BITS-1:1];
  assign odd_ra_b  = idx_b[INDEX_BITS-1:1];
  assign even_wa   = widx_x[INDEX_BITS:1];
  assign odd_wa    = widx_x[INDEX_BITS-1:1];

  // ---------------------------------------------------------------------
  // Table banks: one write port, two registered read ports each.
  // Writes and reads never share a cycle (one request per clock), and a
  // write lands at its accept edge, before any later read.
  // ---------------------------------------------------------------------
  logic [ENTRY_W-1:0] even_mem [EVEN_DEPTH];
  logic [ENTRY_W-1:0] odd_mem  [HALF_DEPTH];
  logic [ENTRY_W-1:0] even_rd_a, even_rd_b, odd_rd_a, odd_rd_b;

  always_ff @(posedge clk) begin
    if (do_write && !widx_x[0]) begin
      even_mem[even_wa] <= in_req.entry_value;
    end
    if (do_comp) begin
      even_rd_a <= even_mem[even_ra_a];
      even_rd_b <= even_mem[even_ra_b];
    end
  end

  always_ff @(posedge clk) begin
    if (do_write && widx_x[0]) begin
      odd_mem[odd_wa] <= in_req.entry_value;
    end
    if (do_comp) begin
      odd_rd_a <= odd_mem[odd_ra_a];
      odd_rd_b <= odd_mem[odd_ra_b];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: table data arrives; pick lo/hi and form base and delta
  // ---------------------------------------------------------------------
  logic [1:0]           quad1;
  logic [FRAC_BITS-1:0] frac1;
  logic                 par_a1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en0) begin
      v1 <= do_comp;
    end
  end

  always_ff @(posedge clk) begin
    if (do_comp) begin
      quad1  <= quad_in;
      frac1  <= frac_in;
      par_a1 <= idx_a[0];
    end
  end

  logic [ENTRY_W-1:0] a_lo, a_hi, b_lo, b_hi;

  // idx_b is the complement of idx_a, so its parity is the opposite
  assign a_lo = par_a1 ? odd_rd_a  : even_rd_a;
  assign a_hi = par_a1 ? even_rd_a : odd_rd_a;
  assign b_lo = par_a1 ? even_rd_b : odd_rd_b;
  assign b_hi = par_a1 ? odd_rd_b  : even_rd_b;

  function automatic lane_t setup_lane(
    input logic [1:0]         q,
    input logic [ENTRY_W-1:0] fwd_lo,
    input logic [ENTRY_W-1:0] fwd_hi,
    input logic [ENTRY_W-1:0] bwd_lo,
    input logic [ENTRY_W-1:0] bwd_hi
  );
    lane_t               l;
    logic [SAMPLE_W-1:0] lo, hi, start;
    lo      = q[0] ? SAMPLE_W'(bwd_lo) : SAMPLE_W'(fwd_lo);
    hi      = q[0] ? SAMPLE_W'(bwd_hi) : SAMPLE_W'(fwd_hi);
    start   = q[0] ? hi : lo;
    l.delta = hi - lo;
    // negation folded into the base: -(b + s) = -b - s, -(b - s) = -b + s
    l.base  = q[1] ? (SAMPLE_W'(0) - start) : start;
    l.add   = (q[0] == q[1]);
    return l;
  endfunction

  lane_t                sin2, cos2;
  logic [FRAC_BITS-1:0] frac2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en1) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && v1) begin
      sin2  <= setup_lane(quad1, a_lo, a_hi, b_lo, b_hi);
      cos2  <= setup_lane(quad1 + 2'd1, a_lo, a_hi, b_lo, b_hi);
      frac2 <= frac1;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: step = (delta * fraction word) >> 32
  // ---------------------------------------------------------------------
  logic [SAMPLE_W-1:0]   frac_word;
  logic [2*SAMPLE_W-1:0] sin_prod, cos_prod;
  sum_t                  sin3, cos3;

  assign frac_word = {REP{frac2}};
  assign sin_prod  = sin2.delta * frac_word;
  assign cos_prod  = cos2.delta * frac_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en2) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v2) begin
      sin3.base <= sin2.base;
      sin3.step <= sin_prod[2*SAMPLE_W-1:SAMPLE_W];
      sin3.add  <= sin2.add;
      cos3.base <= cos2.base;
      cos3.step <= cos_prod[2*SAMPLE_W-1:SAMPLE_W];
      cos3.add  <= cos2.add;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: final add into the output register
  // ---------------------------------------------------------------------
  logic [SAMPLE_W-1:0] sin_sum, cos_sum;
  out_fields_t         res;

  assign sin_sum = sin3.add ? (sin3.base + sin3.step) : (sin3.base - sin3.step);
  assign cos_sum = cos3.add ? (cos3.base + cos3.step) : (cos3.base - cos3.step);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en3) begin
      m_tvalid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v3) begin
      res.sin_value <= sin_sum;
      res.cos_value <= cos_sum;
    end
  end

  assign m_tdata = M_TDATA_W'(res);

endmodule

FILE: rtl/qws_checker.sv
`include "quarter_wave_sincos_interp_core_macros.svh"

module qws_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [qws_pkg::M_TDATA_W-1:0] m_tdata
);
  import qws_pkg::*;

  // response must hold while stalled
  `QWS_ASSERT_NXT(a_m_valid_hold, m_tvalid && !m_tready, m_tvalid, "m_tvalid dropped while stalled")
  `QWS_ASSERT_NXT(a_m_data_hold, m_tvalid && !m_tready, $stable(m_tdata), "m_tdata changed while stalled")
  // reset empties the output stage
  `QWS_ASSERT_IMP(a_rst_clears, $past(rst), !m_tvalid, "response present right after reset")
  // four-stage pipeline: nothing can reach the output sooner
  `QWS_ASSERT_IMP(a_min_latency, $past(rst, 4), !m_tvalid, "response faster than pipeline depth")

endmodule

bind quarter_wave_sincos_interp_core qws_checker u_qws_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: sim/qws_sincos_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the sine/cosine core, keeps its own copy of the
// quarter-wave table and predicts every response in request order.
module qws_sincos_checker #(
  parameter int INDEX_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [qws_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                          s_tuser,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [qws_pkg::M_TDATA_W-1:0] m_tdata,
  output int                            fail_count,
  output int                            pending
);
  import qws_pkg::*;

  localparam int TABLE_MAX = 1 << INDEX_BITS;

  logic [ENTRY_W-1:0] quarter_copy [0:TABLE_MAX];
  out_fields_t        sincos_expected [$];

  // One interpolated sample; all arithmetic wraps at 32 bits.
  function automatic logic [31:0] interp_sample(input logic [1:0] quad,
                                                input int unsigned idx,
                                                input logic [31:0] frac_word);
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] delta;
    logic [31:0] step;
    logic [31:0] value;
    logic [63:0] prod;
    if (quad[0]) begin
      hi = {1'b0, quarter_copy[TABLE_MAX - idx]};
      lo = {1'b0, quarter_copy[TABLE_MAX - 1 - idx]};
    end else begin
      lo = {1'b0, quarter_copy[idx]};
      hi = {1'b0, quarter_copy[idx + 1]};
    end
    delta = hi - lo;
    prod  = {32'd0, delta} * {32'd0, frac_word};
    step  = prod[63:32];
    value = quad[0] ? hi - step : lo + step;
    if (quad[1]) begin
      value = 32'd0 - value;
    end
    return value;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    in_fields_t  req;
    out_fields_t got;
    out_fields_t want;
    logic [TURN_W-1:0] quad_bits;
    logic [1:0]        quad;
    logic [31:0]       frac_word;
    int unsigned       idx;
    int                fails;
    fails = fail_count;
    if (!rst) begin
      // A response can never belong to a request accepted at the same edge.
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (sincos_expected.size() == 0) begin
          $error("response with no compute request outstanding: %h", m_tdata);
          fails++;
        end else begin
          want = sincos_expected.pop_front();
          if (got.sin_value !== want.sin_value) begin
            $error("sin_value: expected %0d, actual %0d", want.sin_value, got.sin_value);
            fails++;
          end
          if (got.cos_value !== want.cos_value) begin
            $error("cos_value: expected %0d, actual %0d", want.cos_value, got.cos_value);
            fails++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        req = s_tdata;
        if (s_tuser == REQ_COMPUTE) begin
          frac_word       = {4{req.turn[FRAC_BITS-1:0]}};
          idx             = (req.turn >> FRAC_BITS) & (TABLE_MAX - 1);
          quad_bits       = req.turn >> (FRAC_BITS + INDEX_BITS);
          quad            = quad_bits[1:0];
          want.sin_value  = interp_sample(quad, idx, frac_word);
          want.cos_value  = interp_sample(quad + 2'd1, idx, frac_word);
          sincos_expected.push_back(want);
        end else if (req.entry_index <= TABLE_MAX) begin
          quarter_copy[req.entry_index] = req.entry_value;
        end
      end
    end
    fail_count <= fails;
    pending    <= sincos_expected.size();
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

// Top of the sine/cosine core bench: drives requests, stalls the response
// side and gives the verdict; all prediction lives in the checker.
module tb;
  import qws_pkg::*;

  localparam int INDEX_BITS = 10;
  localparam int TABLE_MAX  = 1 << INDEX_BITS;
  // entries loaded at each end of the table; computes stay near the ends
  localparam int EDGE       = 64;
  localparam logic [ENTRY_W-1:0] ENTRY_FULL = {ENTRY_W{1'b1}};

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;   // [19:0] turn, [30:20] entry_index, [61:31] entry_value
  logic                 s_tuser;   // [0] req_type
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;   // [31:0] sin_value, [63:32] cos_value

  int fail_count;
  int pending;

  // sender burst bookkeeping
  int burst_left;

  quarter_wave_sincos_interp_core #(
    .INDEX_BITS(INDEX_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  qws_sincos_checker #(
    .INDEX_BITS(INDEX_BITS)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
  end

  always #6 clk = ~clk;

  // Hard stop in case a handshake never completes.
  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

  // Response-side back-pressure. Whenever mode_left runs out, a new stall mode is drawn:
  // always ready, coin flip, mostly stalled, or long stall stretches.
  int stall_mode;
  int mode_left;
  int stall_left;
  initial begin
    stall_mode = 0;
    mode_left  = 0;
    stall_left = 0;
  end

  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = 48;
    end
    mode_left--;
    case (stall_mode)
      0: begin
        m_tready <= 1'b1;
      end
      1: begin
        m_tready <= 1'($urandom_range(0, 1));
      end
      2: begin
        m_tready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        // long stall, then a few ready cycles
        if (stall_left == 0) begin
          stall_left = $urandom_range(4, 24);
        end
        stall_left--;
        m_tready <= (stall_left < 3);
      end
    endcase
  end

  // One request on the input channel. Called right after a falling edge;
  // returns right after the falling edge that follows acceptance. Between
  // bursts the valid line may drop for a random gap.
  task automatic push_request(input req_type_t kind, input logic [TURN_W-1:0] turn,
                              input logic [IDX_W-1:0] entry_index,
                              input logic [ENTRY_W-1:0] entry_value);
    in_fields_t f;
    int         gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    f.pad         = '0;
    f.entry_value = entry_value;
    f.entry_index = entry_index;
    f.turn        = turn;
    s_tvalid <= 1'b1;
    s_tdata  <= f;
    s_tuser  <= kind;
    do begin
      @(posedge clk);
    end while (!s_tready);
    @(negedge clk);
  endtask

  // Writes carry random noise in the turn field, computes in the entry fields.
  task automatic write_entry(input logic [IDX_W-1:0] entry_index,
                             input logic [ENTRY_W-1:0] entry_value);
    logic [31:0] noise;
    noise = $urandom;
    push_request(REQ_WRITE, noise[TURN_W-1:0], entry_index, entry_value);
  endtask

  task automatic compute_turn(input logic [TURN_W-1:0] turn);
    logic [31:0] noise_idx;
    logic [31:0] noise_val;
    noise_idx = $urandom;
    noise_val = $urandom;
    push_request(REQ_COMPUTE, turn, noise_idx[IDX_W-1:0], noise_val[ENTRY_W-1:0]);
  endtask

  function automatic logic [TURN_W-1:0] make_turn(input logic [1:0] quad,
                                                  input int unsigned idx,
                                                  input logic [7:0] frac);
    return {quad, idx[INDEX_BITS-1:0], frac};
  endfunction

  initial begin
    logic [31:0] r;
    logic [31:0] v;
    logic [7:0]  frac;
    int unsigned idx;
    int          accepted;
    int          pick;

    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = REQ_WRITE;
    m_tready   = 1'b0;
    burst_left = 0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Fill both ends of the table. Every compute index stays within EDGE
    // of either end, so forward and backward pairs only read loaded
    // entries. Roughly a rising quarter wave, with jitter and both
    // extremes at the ends.
    for (int k = 0; k <= TABLE_MAX; k++) begin
      if (k > EDGE && k < TABLE_MAX - EDGE) begin
        continue;
      end
      v = k * 2097151 + $urandom_range(0, 4095);
      if (k == 0) begin
        v = 32'd0;
      end else if (k == TABLE_MAX) begin
        v = {1'b0, ENTRY_FULL};
      end
      write_entry(IDX_W'(k), v[ENTRY_W-1:0]);
    end

    // Directed requests.
    // Writes past the last entry are dropped.
    write_entry(IDX_W'(TABLE_MAX + 1), ENTRY_FULL);
    write_entry({IDX_W{1'b1}}, '0);
    // Table ends, every quadrant.
    for (int q = 0; q < 4; q++) begin
      compute_turn(make_turn(2'(q), 0, 8'h00));
      compute_turn(make_turn(2'(q), TABLE_MAX - 1, 8'hFF));
    end
    compute_turn({TURN_W{1'b1}});
    compute_turn(make_turn(2'd0, 0, 8'h80));
    // A falling step between two entries: the difference wraps.
    write_entry(IDX_W'(5), ENTRY_FULL);
    write_entry(IDX_W'(6), '0);
    for (int q = 0; q < 4; q++) begin
      compute_turn(make_turn(2'(q), 5, 8'h80));
    end
    compute_turn(make_turn(2'd1, TABLE_MAX - 6, 8'hFF));
    compute_turn(make_turn(2'd3, TABLE_MAX - 6, 8'h01));

    // Random part: mostly computes, some rewrites of the table, a few
    // dropped writes (those do not count).
    accepted = 0;
    while (accepted < 300) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        r    = $urandom;
        frac = r[7:0];
        idx  = (r >> 8) % EDGE;
        if (r[20]) begin
          idx = TABLE_MAX - 1 - idx;
        end
        case ($urandom_range(0, 15))
          0: frac = 8'h00;
          1: frac = 8'hFF;
          2: idx = 0;
          3: idx = TABLE_MAX - 1;
          default: ;
        endcase
        compute_turn(make_turn(r[31:30], idx, frac));
        accepted++;
      end else if (pick < 92) begin
        v = $urandom;
        case ($urandom_range(0, 7))
          0: v = 32'd0;
          1: v = {1'b0, ENTRY_FULL};
          default: ;
        endcase
        case ($urandom_range(0, 7))
          0: idx = 0;
          1: idx = TABLE_MAX;
          default: begin
            // low end 0..EDGE or high end TABLE_MAX-EDGE..TABLE_MAX
            idx = $urandom_range(0, 2 * EDGE + 1);
            if (idx > EDGE) begin
              idx = idx + TABLE_MAX - 2 * EDGE - 1;
            end
          end
        endcase
        write_entry(IDX_W'(idx), v[ENTRY_W-1:0]);
        accepted++;
      end else begin
        v = $urandom;
        write_entry(IDX_W'($urandom_range(TABLE_MAX + 1, (1 << IDX_W) - 1)),
                    v[ENTRY_W-1:0]);
      end
    end
    s_tvalid <= 1'b0;

    // Drain, then give the pipeline a few more cycles to show stray responses.
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (12) @(negedge clk);

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
